/* rtl/lsmb_pkg.sv */
// Shared constants, types and functions of the laser spot mask block.
package lsmb_pkg;

  localparam int unsigned FRAME_WIDTH  = 320;
  localparam int unsigned FRAME_HEIGHT = 240;
  localparam int unsigned FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned POS_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned GREY_SUM_W = 22;

  localparam logic [LEVEL_W-1:0] RED_THR_RST  = 8'd254;
  localparam logic [LEVEL_W-1:0] GREEN_THR_RST = 8'd0;
  localparam logic [LEVEL_W-1:0] BLUE_THR_RST  = 8'd0;
  localparam logic [LEVEL_W-1:0] DIFF_THR_RST  = 8'd80;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RED_THR   = 3'd0,
    CFG_GREEN_THR = 3'd1,
    CFG_BLUE_THR  = 3'd2,
    CFG_DIFF_THR  = 3'd3,
    CFG_BG_ON     = 3'd4
  } cfg_idx_e;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [POS_W-1:0]   pos_t;

  // Luma weights scaled by 2^14, rounded.
  function automatic level_t grey_of(level_t r, level_t g, level_t b);
    logic [GREY_SUM_W-1:0] sum;
    sum = GREY_SUM_W'(r) * GREY_SUM_W'(4899) + GREY_SUM_W'(g) * GREY_SUM_W'(9617)
        + GREY_SUM_W'(b) * GREY_SUM_W'(1868) + GREY_SUM_W'(8192);
    return sum[GREY_SUM_W-1 -: LEVEL_W];
  endfunction

endpackage

/* rtl/lsmb_ram.sv */
// Generic simple dual-port RAM with registered read.
module lsmb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/laser_spot_mask_with_background.sv */
// Top level of the laser spot mask with background removal.
//
// One RGB pixel word is taken per clock and one mask word comes out per pixel, in order; the
// sustained rate is one pixel per cycle without output stalls, set by the single-port-per-side
// background RAM (one read at accept, one write as the pixel leaves the compute stage).
// A pixel is masked on when each color exceeds its threshold and, with background removal
// on, its grey level exceeds the stored background by more than the difference threshold.
// The first frame after reset, and any frame whose first pixel carries capture_request,
// is stored as the new background. Background entries hold no reset value.
module laser_spot_mask_with_background import lsmb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [LEVEL_W-1:0]   red_level_i,
  input  logic [LEVEL_W-1:0]   green_level_i,
  input  logic [LEVEL_W-1:0]   blue_level_i,
  input  logic                 frame_start_i,
  input  logic                 capture_request_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 laser_mask_o
);

  level_t red_thr_q, green_thr_q, blue_thr_q, diff_thr_q;
  logic   bg_on_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_thr_q   <= RED_THR_RST;
      green_thr_q <= GREEN_THR_RST;
      blue_thr_q  <= BLUE_THR_RST;
      diff_thr_q  <= DIFF_THR_RST;
      bg_on_q     <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RED_THR:   red_thr_q   <= cfg_data_i;
        CFG_GREEN_THR: green_thr_q <= cfg_data_i;
        CFG_BLUE_THR:  blue_thr_q  <= cfg_data_i;
        CFG_DIFF_THR:  diff_thr_q  <= cfg_data_i;
        CFG_BG_ON:     bg_on_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Frame position tracking.
  pos_t pos_q, pos_d, cur_pos;
  logic learn_q, learn_d, cur_learn;
  logic seen_q, seen_d;
  logic in_acc;

  // Compute stage.
  logic   a_valid_q, a_advance;
  level_t a_red_q, a_green_q, a_blue_q;
  pos_t   a_pos_q;
  logic   a_learn_q;
  logic   fwd_hit_q;
  level_t fwd_data_q;

  logic out_valid_q, out_mask_q;

  assign a_advance  = a_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !a_valid_q || a_advance;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    cur_learn = learn_q;
    seen_d    = seen_q;
    cur_pos   = pos_q;
    if (frame_start_i) begin
      cur_pos   = '0;
      cur_learn = seen_q ? capture_request_i : 1'b1;
      seen_d    = 1'b1;
    end
    learn_d = cur_learn;
    if (32'(cur_pos) + 32'd1 >= FRAME_PIXELS) begin
      pos_d   = '0;
      learn_d = 1'b0;
      seen_d  = 1'b1;
    end else begin
      pos_d = cur_pos + pos_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      learn_q <= 1'b1;
      seen_q  <= 1'b0;
    end else if (in_acc) begin
      pos_q   <= pos_d;
      learn_q <= learn_d;
      seen_q  <= seen_d;
    end
  end

  level_t a_grey, ram_rdata, bg;
  logic   color_ok, diff_ok, a_mask;

  assign a_grey   = grey_of(a_red_q, a_green_q, a_blue_q);
  assign bg       = fwd_hit_q ? fwd_data_q : ram_rdata;
  assign color_ok = (a_red_q > red_thr_q) && (a_green_q > green_thr_q)
                 && (a_blue_q > blue_thr_q);
  // A learning pixel compares against itself, so its difference is zero.
  assign diff_ok  = !a_learn_q && (a_grey > bg) && ((a_grey - bg) > diff_thr_q);
  assign a_mask   = color_ok && (!bg_on_q || diff_ok);

  lsmb_ram #(
    .WIDTH(LEVEL_W),
    .DEPTH(FRAME_PIXELS)
  ) u_bg_ram (
    .clk_i   (clk_i),
    .we_i    (a_advance && a_learn_q),
    .waddr_i (a_pos_q),
    .wdata_i (a_grey),
    .re_i    (in_acc),
    .raddr_i (cur_pos),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      if (in_acc) begin
        a_valid_q <= 1'b1;
        // Write in flight on the read edge: forward it.
        fwd_hit_q <= a_advance && a_learn_q && (a_pos_q == cur_pos);
      end else if (a_advance) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_red_q    <= red_level_i;
      a_green_q  <= green_level_i;
      a_blue_q   <= blue_level_i;
      a_pos_q    <= cur_pos;
      a_learn_q  <= cur_learn;
      fwd_data_q <= a_grey;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (a_advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_advance) begin
      out_mask_q <= a_mask;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign laser_mask_o = out_mask_q;

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) < FRAME_PIXELS)
    else $error("frame position out of range");

  a_unseen_learns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> learn_q)
    else $error("first frame not learned");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_advance |=> out_valid_q)
    else $error("result lost on advance");

  a_fwd_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && a_advance && a_learn_q && (a_pos_q == cur_pos)) |=> fwd_hit_q)
    else $error("missed write forward");

endmodule

/* tb/tb.sv */
// Self-checking testbench of the laser spot mask block with background removal.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsmb_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1050;
  localparam int unsigned MAX_GAP        = 15;
  localparam int unsigned DRAIN_CYCLES   = 6;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;

  // Predicts mask words from accepted pixels and checks the words that come out.
  class mask_scoreboard;
    level_t      bg_mem [FRAME_PIXELS];
    int unsigned pos;
    int unsigned extent;
    bit          learning;
    bit          seen;
    level_t      red_thr, green_thr, blue_thr, diff_thr;
    bit          bg_on;
    bit          mask_q[$];
    int unsigned mismatches;
    int unsigned words_checked;

    function new();
      pos           = 0;
      extent        = 0;
      learning      = 1'b1;
      seen          = 1'b0;
      red_thr       = RED_THR_RST;
      green_thr     = GREEN_THR_RST;
      blue_thr      = BLUE_THR_RST;
      diff_thr      = DIFF_THR_RST;
      bg_on         = 1'b1;
      mismatches    = 0;
      words_checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, level_t data);
      case (idx)
        CFG_RED_THR:   red_thr = data;
        CFG_GREEN_THR: green_thr = data;
        CFG_BLUE_THR:  blue_thr = data;
        CFG_DIFF_THR:  diff_thr = data;
        CFG_BG_ON:     bg_on = data[0];
        default: ;
      endcase
    endfunction

    function void note_pixel(level_t r, level_t g, level_t b, bit fs, bit cap);
      int unsigned sum;
      int unsigned diff;
      int unsigned p;
      level_t      grey;
      bit          mask;
      if (fs) begin
        pos      = 0;
        learning = seen ? cap : 1'b1;
        seen     = 1'b1;
      end
      p = (pos >= FRAME_PIXELS) ? 0 : pos;
      mask = (r > red_thr) && (g > green_thr) && (b > blue_thr);
      sum = 4899 * int'(r) + 9617 * int'(g) + 1868 * int'(b) + 8192;
      grey = level_t'(sum >> 14);
      if (learning) begin
        bg_mem[p] = grey;
        if (p + 1 > extent) extent = p + 1;
      end
      if (bg_on) begin
        diff = (grey > bg_mem[p]) ? int'(grey) - int'(bg_mem[p]) : 0;
        if (!(diff > int'(diff_thr))) mask = 1'b0;
      end
      if (p + 1 >= FRAME_PIXELS) begin
        pos      = 0;
        learning = 1'b0;
        seen     = 1'b1;
      end else begin
        pos = p + 1;
      end
      mask_q.push_back(mask);
    endfunction

    function void check_mask(logic got);
      bit want;
      if (mask_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("word %0d: laser_mask expected none, got %b", words_checked, got);
        mismatches++;
      end else begin
        want = mask_q.pop_front();
        if (got !== want) begin
          if (mismatches < MAX_REPORTS)
            $display("word %0d: laser_mask expected %b, got %b", words_checked, want, got);
          mismatches++;
        end
      end
      words_checked++;
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  level_t               red_level_i;
  level_t               green_level_i;
  level_t               blue_level_i;
  logic                 frame_start_i;
  logic                 capture_request_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 laser_mask_o;

  mask_scoreboard sb = new();
  bit             gaps_on = 1'b1;
  int unsigned    frame_left = 0;
  int unsigned    quiet_cycles = 0;

  laser_spot_mask_with_background dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .red_level_i       (red_level_i),
    .green_level_i     (green_level_i),
    .blue_level_i      (blue_level_i),
    .frame_start_i     (frame_start_i),
    .capture_request_i (capture_request_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .laser_mask_o      (laser_mask_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic level_t pick_level();
    case ($urandom_range(0, 3))
      0: return level_t'($urandom_range(0, 255));
      1: return level_t'($urandom_range(0, 40));
      2: return level_t'($urandom_range(200, 255));
      default: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    endcase
  endfunction

  function automatic level_t pick_threshold();
    case ($urandom_range(0, 3))
      0: return level_t'($urandom_range(0, 255));
      1: return level_t'($urandom_range(0, 48));
      2: return 8'd0;
      default: return level_t'($urandom_range(150, 255));
    endcase
  endfunction

  task automatic send_pixel(level_t r, level_t g, level_t b, bit fs, bit cap);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    red_level_i       <= r;
    green_level_i     <= g;
    blue_level_i      <= b;
    frame_start_i     <= fs;
    capture_request_i <= cap;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(r, g, b, fs, cap);
  endtask

  task automatic send_random_pixel(bit fs, bit cap);
    send_pixel(pick_level(), pick_level(), pick_level(), fs, cap);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.mask_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, level_t data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_setting(level_t r, level_t g, level_t b, level_t d, bit on);
    drain();
    // index past the register list, must be ignored
    write_reg(CFG_IDX_W'(int'(CFG_BG_ON) + $urandom_range(1, 3)), level_t'($urandom));
    write_reg(CFG_RED_THR, r);
    write_reg(CFG_GREEN_THR, g);
    write_reg(CFG_BLUE_THR, b);
    write_reg(CFG_DIFF_THR, d);
    write_reg(CFG_BG_ON, level_t'({7'($urandom), on}));
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_setting();
    case ($urandom_range(0, 5))
      0: apply_setting(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      1: apply_setting(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      2: apply_setting(RED_THR_RST, GREEN_THR_RST, BLUE_THR_RST, DIFF_THR_RST, 1'b1);
      default: apply_setting(pick_threshold(), pick_threshold(), pick_threshold(),
                             pick_threshold(), 1'(($urandom_range(0, 1))));
    endcase
  endtask

  // Frames start at position 0; a compare frame never runs past the learned extent.
  task automatic run_frames(int unsigned n);
    int unsigned len;
    bit          fs;
    bit          cap;
    repeat (n) begin
      if (frame_left == 0 || $urandom_range(0, 39) == 0) begin
        fs  = 1'b1;
        cap = ($urandom_range(0, 3) == 0);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 64);
        if (!cap && len > sb.extent) len = sb.extent;
        frame_left = len;
      end else begin
        fs  = 1'b0;
        cap = 1'($urandom_range(0, 1));
      end
      send_random_pixel(fs, cap);
      frame_left--;
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_index_i       <= '0;
    cfg_data_i        <= '0;
    in_valid_i        <= 1'b0;
    red_level_i       <= '0;
    green_level_i     <= '0;
    blue_level_i      <= '0;
    frame_start_i     <= 1'b0;
    capture_request_i <= 1'b0;
    out_ready_i       <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pixels before the first frame start, then the first frame: both learned
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b0, 1'b1);
    send_pixel(8'd40, 8'd40, 8'd40, 1'b0, 1'b0);

    // color test alone
    apply_setting(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    send_pixel(8'd1, 8'd1, 8'd1, 1'b0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd0, 1'b0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd255, 1'b0, 1'b0);
    send_pixel(8'd200, 8'd200, 8'd200, 1'b0, 1'b0);

    // background difference against the learned frame
    apply_setting(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
    send_pixel(8'd1, 8'd1, 8'd1, 1'b0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd1, 1'b0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);

    // captured frame with all thresholds at the top
    apply_setting(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    send_pixel(8'd128, 8'd127, 8'd1, 1'b0, 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      random_setting();
      gaps_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(40, 120);
      run_frames(n);
      sent += n;
    end

    drain();
    repeat (4 * DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.mask_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_mask(laser_mask_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule
